// ===== rtl/lcdx_pkg.sv =====
// Shared types and constants for the character LCD expander driver.
`timescale 1ns / 1ps

package lcdx_pkg;

   // Input word: one command
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] char_code;
      logic [5:0] column;
      logic [1:0] row;
      logic       backlight_on;
   } req_type;

   // Output word: one expander port byte
   typedef struct packed {
      logic [7:0]  port_byte;
      logic [14:0] wait_us;
      logic [5:0]  cursor_column;
      logic [2:0]  cursor_row;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] line_count;
      logic [5:0] line_length;
      logic [6:0] line1_start;
      logic [6:0] line2_start;
      logic [6:0] line3_start;
      logic [6:0] line4_start;
   } cfg_type;

   // Queue entry between front and back
   typedef struct packed {
      logic [1:0] op;
      logic       rs;
      logic [7:0] data;
      logic       last;
      logic [5:0] col;
      logic [2:0] row;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_LINE_COUNT  = 3'd0;
   localparam logic [2:0] REG_LINE_LENGTH = 3'd1;
   localparam logic [2:0] REG_LINE1_START = 3'd2;
   localparam logic [2:0] REG_LINE2_START = 3'd3;
   localparam logic [2:0] REG_LINE3_START = 3'd4;
   localparam logic [2:0] REG_LINE4_START = 3'd5;

   localparam logic [2:0] CFG_LINE_COUNT_RST  = 3'd2;
   localparam logic [5:0] CFG_LINE_LENGTH_RST = 6'd16;
   localparam logic [6:0] CFG_LINE1_RST       = 7'd0;
   localparam logic [6:0] CFG_LINE2_RST       = 7'd64;
   localparam logic [6:0] CFG_LINE3_RST       = 7'd20;
   localparam logic [6:0] CFG_LINE4_RST       = 7'd84;

   localparam logic [2:0] CMD_INIT      = 3'd0;
   localparam logic [2:0] CMD_PUT       = 3'd1;
   localparam logic [2:0] CMD_GOTO      = 3'd2;
   localparam logic [2:0] CMD_CLEAR     = 3'd3;
   localparam logic [2:0] CMD_BACKLIGHT = 3'd4;

   localparam logic [1:0] OP_PRE  = 2'd0;   // power-up nibble preamble
   localparam logic [1:0] OP_SEND = 2'd1;   // one LCD byte as two nibbles
   localparam logic [1:0] OP_BL   = 2'd2;   // backlight port update

   localparam logic [7:0] RS_BIT   = 8'h10;
   localparam logic [7:0] E_BIT    = 8'h20;
   localparam logic [7:0] BL_BIT   = 8'h40;
   localparam logic [7:0] HI_MASK  = 8'hF0;

   localparam logic [7:0] LCD_FUNC_SET = 8'h28;
   localparam logic [7:0] LCD_DISP_OFF = 8'h08;
   localparam logic [7:0] LCD_ENTRY    = 8'h06;
   localparam logic [7:0] LCD_CLEAR    = 8'h01;
   localparam logic [7:0] LCD_SET_ADDR = 8'h80;
   localparam logic [7:0] CHAR_NL      = 8'h0A;

   localparam logic [3:0] NIB_INIT3 = 4'h3;
   localparam logic [3:0] NIB_INIT2 = 4'h2;

   localparam logic [14:0] WAIT_NONE  = 15'd0;
   localparam logic [14:0] WAIT_PULSE = 15'd1;
   localparam logic [14:0] WAIT_CMD   = 15'd40;
   localparam logic [14:0] WAIT_PWR   = 15'd20000;
   localparam logic [14:0] WAIT_INIT1 = 15'd4992;
   localparam logic [14:0] WAIT_INIT2 = 15'd50;
   localparam logic [14:0] WAIT_INIT3 = 15'd64;

   localparam logic [3:0] PRE_LAST  = 4'd11;
   localparam logic [3:0] SEND_LAST = 4'd6;

endpackage

// ===== rtl/lcdx_csr.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module lcdx_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lcdx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output lcdx_pkg::cfg_type               cfg
);

   lcdx_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        idx;

   assign idx    = paddr[lcdx_pkg::CSR_ADDR_W-1:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            lcdx_pkg::REG_LINE_COUNT:  cfg_in.line_count  = pwdata[2:0];
            lcdx_pkg::REG_LINE_LENGTH: cfg_in.line_length = pwdata[5:0];
            lcdx_pkg::REG_LINE1_START: cfg_in.line1_start = pwdata[6:0];
            lcdx_pkg::REG_LINE2_START: cfg_in.line2_start = pwdata[6:0];
            lcdx_pkg::REG_LINE3_START: cfg_in.line3_start = pwdata[6:0];
            lcdx_pkg::REG_LINE4_START: cfg_in.line4_start = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         lcdx_pkg::REG_LINE_COUNT:  prdata = {29'd0, cfg_ff.line_count};
         lcdx_pkg::REG_LINE_LENGTH: prdata = {26'd0, cfg_ff.line_length};
         lcdx_pkg::REG_LINE1_START: prdata = {25'd0, cfg_ff.line1_start};
         lcdx_pkg::REG_LINE2_START: prdata = {25'd0, cfg_ff.line2_start};
         lcdx_pkg::REG_LINE3_START: prdata = {25'd0, cfg_ff.line3_start};
         lcdx_pkg::REG_LINE4_START: prdata = {25'd0, cfg_ff.line4_start};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_count  <= lcdx_pkg::CFG_LINE_COUNT_RST;
         cfg_ff.line_length <= lcdx_pkg::CFG_LINE_LENGTH_RST;
         cfg_ff.line1_start <= lcdx_pkg::CFG_LINE1_RST;
         cfg_ff.line2_start <= lcdx_pkg::CFG_LINE2_RST;
         cfg_ff.line3_start <= lcdx_pkg::CFG_LINE3_RST;
         cfg_ff.line4_start <= lcdx_pkg::CFG_LINE4_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/lcdx_front.sv =====
// Command front end: tracks the cursor and splits commands into queue entries.
`timescale 1ns / 1ps

module lcdx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  lcdx_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lcdx_pkg::req_type     req_payload,
   input  lcdx_pkg::q_stat_type  q_stat,
   output logic                  push,
   output lcdx_pkg::entry_type   push_entry
);

   typedef enum logic {F_IDLE, F_EMIT} fstate_type;

   fstate_type state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic [2:0] fstep_ff, fstep_in;
   logic [2:0] flast_ff, flast_in;
   logic [7:0] b0_ff, b0_in, b1_ff, b1_in, ch_ff, ch_in;
   logic       rs0_ff, rs0_in, rs1_ff, rs1_in;
   logic [5:0] cx_ff, cx_in;
   logic [2:0] cy_ff, cy_in;

   logic       acc, wrap;
   logic [2:0] y1, cy1, y2, gy;
   logic [5:0] cx1, gx;

   // row equal to the line count folds back to the top line
   function automatic logic [2:0] adj_row(input logic [2:0] y, input logic [2:0] lc);
      return (y == lc) ? 3'd0 : y;
   endfunction

   function automatic logic [7:0] line_addr(input logic [2:0] y, input logic [5:0] x,
                                            input lcdx_pkg::cfg_type c);
      logic [6:0] start;
      if (c.line_count <= 3'd1)
         start = c.line1_start;
      else if (c.line_count == 3'd2)
         start = (y == 3'd0) ? c.line1_start : c.line2_start;
      else begin
         case (y)
            3'd0:    start = c.line1_start;
            3'd1:    start = c.line2_start;
            3'd2:    start = c.line3_start;
            default: start = c.line4_start;
         endcase
      end
      return lcdx_pkg::LCD_SET_ADDR + {1'b0, start} + {2'b00, x};
   endfunction

   function automatic logic [7:0] init_byte(input logic [2:0] s, input logic [7:0] ch);
      case (s)
         3'd1:    return lcdx_pkg::LCD_FUNC_SET;
         3'd2:    return lcdx_pkg::LCD_DISP_OFF;
         3'd3:    return lcdx_pkg::LCD_ENTRY;
         3'd4:    return lcdx_pkg::LCD_CLEAR;
         3'd5:    return lcdx_pkg::LCD_SET_ADDR;
         default: return ch;
      endcase
   endfunction

   assign acc       = req_valid && (state_ff == F_IDLE);
   assign req_stall = (state_ff != F_IDLE);

   // put character: optional wrap to next line, then the character or a newline
   assign wrap = (cx_ff == cfg.line_length);
   assign y1   = adj_row(3'(cy_ff + 3'd1), cfg.line_count);
   assign cx1  = wrap ? 6'd0 : cx_ff;
   assign cy1  = wrap ? y1 : cy_ff;
   assign y2   = adj_row(3'(cy1 + 3'd1), cfg.line_count);
   // goto
   assign gy   = adj_row({1'b0, req_payload.row}, cfg.line_count);
   assign gx   = (req_payload.column == cfg.line_length) ? 6'd0 : req_payload.column;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      fstep_in = fstep_ff;
      flast_in = flast_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      rs0_in   = rs0_ff;
      rs1_in   = rs1_ff;
      ch_in    = ch_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      push     = 1'b0;

      if (acc) begin
         kind_in  = req_payload.command;
         fstep_in = 3'd0;
         flast_in = 3'd0;
         rs0_in   = 1'b0;
         case (req_payload.command)
            lcdx_pkg::CMD_INIT: begin
               state_in = F_EMIT;
               flast_in = 3'd6;
               ch_in    = req_payload.char_code;
               cx_in    = 6'd0;
               cy_in    = 3'd0;
            end
            lcdx_pkg::CMD_PUT: begin
               state_in = F_EMIT;
               fstep_in = wrap ? 3'd0 : 3'd1;
               flast_in = 3'd1;
               b0_in    = line_addr(y1, 6'd0, cfg);
               if (req_payload.char_code != lcdx_pkg::CHAR_NL) begin
                  b1_in  = req_payload.char_code;
                  rs1_in = 1'b1;
                  cx_in  = 6'(cx1 + 6'd1);
                  cy_in  = cy1;
               end else begin
                  b1_in  = line_addr(y2, 6'd0, cfg);
                  rs1_in = 1'b0;
                  cx_in  = 6'd0;
                  cy_in  = y2;
               end
            end
            lcdx_pkg::CMD_GOTO: begin
               state_in = F_EMIT;
               b0_in    = line_addr(gy, gx, cfg);
               cx_in    = gx;
               cy_in    = gy;
            end
            lcdx_pkg::CMD_CLEAR: begin
               state_in = F_EMIT;
               b0_in    = lcdx_pkg::LCD_CLEAR;
               cx_in    = 6'd0;
               cy_in    = 3'd0;
            end
            lcdx_pkg::CMD_BACKLIGHT: begin
               state_in = F_EMIT;
               ch_in    = {7'd0, req_payload.backlight_on};
            end
            default: ;   // unused codes are dropped
         endcase
      end else if (state_ff == F_EMIT && !q_stat.full) begin
         push = 1'b1;
         if (fstep_ff == flast_ff)
            state_in = F_IDLE;
         else
            fstep_in = 3'(fstep_ff + 3'd1);
      end
   end

   always_comb begin
      push_entry.last = (fstep_ff == flast_ff);
      push_entry.col  = cx_ff;
      push_entry.row  = cy_ff;
      case (kind_ff)
         lcdx_pkg::CMD_INIT: begin
            push_entry.op   = (fstep_ff == 3'd0) ? lcdx_pkg::OP_PRE : lcdx_pkg::OP_SEND;
            push_entry.rs   = 1'b0;
            push_entry.data = init_byte(fstep_ff, ch_ff);
         end
         lcdx_pkg::CMD_BACKLIGHT: begin
            push_entry.op   = lcdx_pkg::OP_BL;
            push_entry.rs   = 1'b0;
            push_entry.data = ch_ff;
         end
         default: begin
            push_entry.op   = lcdx_pkg::OP_SEND;
            push_entry.rs   = (fstep_ff == 3'd0) ? rs0_ff : rs1_ff;
            push_entry.data = (fstep_ff == 3'd0) ? b0_ff : b1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cx_ff    <= 6'd0;
         cy_ff    <= 3'd0;
         fstep_ff <= 3'd0;
         flast_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         fstep_ff <= fstep_in;
         flast_ff <= flast_in;
      end
      kind_ff <= kind_in;
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      rs0_ff  <= rs0_in;
      rs1_ff  <= rs1_in;
      ch_ff   <= ch_in;
   end

endmodule

// ===== rtl/lcdx_queue.sv =====
// Small FIFO of operations between the front end and the byte sequencer.
`timescale 1ns / 1ps

module lcdx_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lcdx_pkg::entry_type  push_entry,
   input  logic                 pop,
   output lcdx_pkg::entry_type  head,
   output lcdx_pkg::q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcdx_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign head         = store_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         store_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== rtl/lcdx_back.sv =====
// Byte sequencer: turns queued operations into expander port bytes.
`timescale 1ns / 1ps

module lcdx_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lcdx_pkg::entry_type  head,
   input  lcdx_pkg::q_stat_type q_stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lcdx_pkg::rsp_type    rsp_payload
);

   typedef enum logic {B_IDLE, B_RUN} bstate_type;

   bstate_type          state_ff, state_in;
   lcdx_pkg::entry_type cur_ff, cur_in;
   logic [3:0]          bstep_ff, bstep_in;
   logic [7:0]          shadow_ff, shadow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lcdx_pkg::rsp_type   rsp_ff, rsp_in;

   logic [7:0]  gen_byte;
   logic [14:0] gen_wait;
   logic [3:0]  end_step;
   logic        adv;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign adv         = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cur_ff.op)
         lcdx_pkg::OP_PRE:  end_step = lcdx_pkg::PRE_LAST;
         lcdx_pkg::OP_SEND: end_step = lcdx_pkg::SEND_LAST;
         default:           end_step = 4'd0;
      endcase
   end

   // byte for the current step, built on the shadow of the port
   always_comb begin
      gen_byte = shadow_ff;
      gen_wait = lcdx_pkg::WAIT_NONE;
      case (cur_ff.op)
         lcdx_pkg::OP_SEND: begin
            case (bstep_ff)
               4'd0: begin
                  gen_byte = cur_ff.rs ? (shadow_ff | lcdx_pkg::RS_BIT)
                                       : (shadow_ff & ~lcdx_pkg::RS_BIT);
                  gen_wait = lcdx_pkg::WAIT_PULSE;
               end
               4'd1: gen_byte = (shadow_ff & lcdx_pkg::HI_MASK) | {4'd0, cur_ff.data[7:4]};
               4'd4: gen_byte = (shadow_ff & lcdx_pkg::HI_MASK) | {4'd0, cur_ff.data[3:0]};
               4'd2, 4'd5: begin
                  gen_byte = shadow_ff | lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_PULSE;
               end
               4'd3: begin
                  gen_byte = shadow_ff & ~lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_PULSE;
               end
               default: begin
                  gen_byte = shadow_ff & ~lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_CMD;
               end
            endcase
         end
         lcdx_pkg::OP_PRE: begin
            case (bstep_ff)
               4'd0: begin
                  gen_byte = 8'h00;
                  gen_wait = lcdx_pkg::WAIT_PWR;
               end
               4'd1: gen_byte = shadow_ff & ~lcdx_pkg::RS_BIT;
               4'd2: gen_byte = (shadow_ff & lcdx_pkg::HI_MASK) | {4'd0, lcdx_pkg::NIB_INIT3};
               4'd9: gen_byte = (shadow_ff & lcdx_pkg::HI_MASK) | {4'd0, lcdx_pkg::NIB_INIT2};
               4'd3, 4'd5, 4'd7, 4'd10: begin
                  gen_byte = shadow_ff | lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_PULSE;
               end
               4'd4: begin
                  gen_byte = shadow_ff & ~lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_INIT1;
               end
               4'd6: begin
                  gen_byte = shadow_ff & ~lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_INIT2;
               end
               default: begin
                  gen_byte = shadow_ff & ~lcdx_pkg::E_BIT;
                  gen_wait = lcdx_pkg::WAIT_INIT3;
               end
            endcase
         end
         default: begin
            // backlight is active low
            gen_byte = cur_ff.data[0] ? (shadow_ff & ~lcdx_pkg::BL_BIT)
                                      : (shadow_ff | lcdx_pkg::BL_BIT);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      bstep_in     = bstep_ff;
      shadow_in    = shadow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               cur_in   = head;
               bstep_in = 4'd0;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (adv) begin
               rsp_valid_in         = 1'b1;
               rsp_in.port_byte     = gen_byte;
               rsp_in.wait_us       = gen_wait;
               rsp_in.cursor_column = cur_ff.col;
               rsp_in.cursor_row    = cur_ff.row;
               rsp_in.last          = cur_ff.last && (bstep_ff == end_step);
               shadow_in            = gen_byte;
               if (bstep_ff == end_step)
                  state_in = B_IDLE;
               else
                  bstep_in = 4'(bstep_ff + 4'd1);
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         bstep_ff     <= 4'd0;
         shadow_ff    <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bstep_ff     <= bstep_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/char_lcd_expander_driver.sv =====
// Top level of the character LCD driver over an 8-bit port expander.
//
// Drives a character LCD controller in 4-bit mode. Each command word on the
// req_ channel (init, put character, goto, clear, backlight) becomes a run of
// expander port bytes on the rsp_ channel, each with its wait time and the
// cursor position after the command; last marks the final byte of the run.
// The front end accepts one command, updates the cursor and splits it into
// LCD operations (one per LCD byte, the power-up preamble or a backlight update) in a queue;
// the back end sequences each operation into port bytes, one per cycle while
// rsp_stall is low. An LCD byte is 7 port bytes, and each operation is first
// fetched from the queue; a put character gives 7 or 14 port bytes, goto and
// clear 7, backlight 1 and init 54; the back-end sequencer sets the pace.
// A new command is taken once the previous one is fully queued.
// Reset: cursor at column 0 row 0, port shadow 0, registers at their
// defaults. While rsp_stall is high the output word holds, the queue fills
// and req_stall rises; nothing is lost.
`timescale 1ns / 1ps

module char_lcd_expander_driver #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lcdx_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lcdx_pkg::rsp_type               rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lcdx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   lcdx_pkg::cfg_type    cfg;
   lcdx_pkg::q_stat_type q_stat;
   lcdx_pkg::entry_type  push_entry, head;
   logic                 push, pop;

   lcdx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // command decode and cursor tracking
   lcdx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_entry  (push_entry)
   );

   // decouples decode from byte sequencing
   lcdx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // port byte sequencer with registered output word
   lcdx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== test/char_lcd_expander_driver_tb.sv =====
// Self-checking testbench for the character LCD expander driver.
`timescale 1ns / 1ps

module char_lcd_expander_driver_tb;

   // Command codes the block ignores
   localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int ITEMS_PER_PHASE = 51;
   localparam int SETTLE_CYCLES   = 16;   // front end may still chew on an ignored word
   localparam int TAIL_CYCLES     = 30;
   localparam int MAX_PRINTED     = 40;

   // Clock, reset and stimulus; every input has a known value from time zero
   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   lcdx_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   lcdx_pkg::rsp_type rsp_payload;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [lcdx_pkg::CSR_ADDR_W-1:0] paddr  = '0;
   logic [31:0]                     pwdata = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   char_lcd_expander_driver dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: own copy of the port shadow, cursor and line setup
   // ---------------------------------------------------------------------
   logic [7:0]        shadow_byte = 8'h00;
   logic [5:0]        cur_col     = 6'd0;
   logic [2:0]        cur_row     = 3'd0;
   lcdx_pkg::cfg_type lines_cfg   = '{lcdx_pkg::CFG_LINE_COUNT_RST,
                                      lcdx_pkg::CFG_LINE_LENGTH_RST,
                                      lcdx_pkg::CFG_LINE1_RST, lcdx_pkg::CFG_LINE2_RST,
                                      lcdx_pkg::CFG_LINE3_RST, lcdx_pkg::CFG_LINE4_RST};

   lcdx_pkg::rsp_type port_run[$];        // port words of the command being expanded
   lcdx_pkg::rsp_type port_words_due[$];  // expected port words, oldest first

   // Every port write updates the shadow, as the expander would
   function automatic void drive_port(logic [7:0] b, logic [14:0] w);
      lcdx_pkg::rsp_type r;
      r = '0;
      r.port_byte = b;
      r.wait_us = w;
      shadow_byte = b;
      port_run.push_back(r);
   endfunction

   function automatic void send_nibble(logic [3:0] n, logic [14:0] w);
      drive_port({shadow_byte[7:4], n}, w);
   endfunction

   function automatic void pulse_enable(logic [14:0] w_after);
      drive_port(shadow_byte | lcdx_pkg::E_BIT, lcdx_pkg::WAIT_PULSE);
      drive_port(shadow_byte & ~lcdx_pkg::E_BIT, w_after);
   endfunction

   // One LCD byte: RS, high nibble, E pulse, low nibble, E pulse
   function automatic void send_lcd_byte(logic rs, logic [7:0] b);
      drive_port(rs ? (shadow_byte | lcdx_pkg::RS_BIT) : (shadow_byte & ~lcdx_pkg::RS_BIT),
                 lcdx_pkg::WAIT_PULSE);
      send_nibble(b[7:4], lcdx_pkg::WAIT_NONE);
      pulse_enable(lcdx_pkg::WAIT_PULSE);
      send_nibble(b[3:0], lcdx_pkg::WAIT_NONE);
      pulse_enable(lcdx_pkg::WAIT_CMD);
   endfunction

   // Cursor move: row and column wrap only when exactly at the limit
   function automatic void move_cursor(logic [5:0] x, logic [2:0] y);
      logic [6:0] base;
      logic [7:0] addr;
      if (y == lines_cfg.line_count) y = 3'd0;
      if (x == lines_cfg.line_length) x = 6'd0;
      cur_col = x;
      cur_row = y;
      if (lines_cfg.line_count <= 3'd1)
         base = lines_cfg.line1_start;
      else if (lines_cfg.line_count == 3'd2)
         base = (y == 3'd0) ? lines_cfg.line1_start : lines_cfg.line2_start;
      else begin
         case (y)
            3'd0: base = lines_cfg.line1_start;
            3'd1: base = lines_cfg.line2_start;
            3'd2: base = lines_cfg.line3_start;
            default: base = lines_cfg.line4_start;
         endcase
      end
      addr = lcdx_pkg::LCD_SET_ADDR + {1'b0, base} + {2'b00, x};
      send_lcd_byte(1'b0, addr);
   endfunction

   // Expands one command word into its run of port words in port_run
   function automatic void expand_command(lcdx_pkg::req_type w);
      port_run.delete();
      case (w.command)
         lcdx_pkg::CMD_INIT: begin
            drive_port(8'h00, lcdx_pkg::WAIT_PWR);
            drive_port(shadow_byte & ~lcdx_pkg::RS_BIT, lcdx_pkg::WAIT_NONE);
            send_nibble(lcdx_pkg::NIB_INIT3, lcdx_pkg::WAIT_NONE);
            pulse_enable(lcdx_pkg::WAIT_INIT1);
            pulse_enable(lcdx_pkg::WAIT_INIT2);
            pulse_enable(lcdx_pkg::WAIT_INIT3);
            send_nibble(lcdx_pkg::NIB_INIT2, lcdx_pkg::WAIT_NONE);
            pulse_enable(lcdx_pkg::WAIT_INIT3);
            send_lcd_byte(1'b0, lcdx_pkg::LCD_FUNC_SET);
            send_lcd_byte(1'b0, lcdx_pkg::LCD_DISP_OFF);
            send_lcd_byte(1'b0, lcdx_pkg::LCD_ENTRY);
            send_lcd_byte(1'b0, lcdx_pkg::LCD_CLEAR);
            send_lcd_byte(1'b0, lcdx_pkg::LCD_SET_ADDR);
            send_lcd_byte(1'b0, w.char_code);
            cur_col = 6'd0;
            cur_row = 3'd0;
         end
         lcdx_pkg::CMD_PUT: begin
            // at line end the cursor first moves to the next row
            if (cur_col == lines_cfg.line_length) move_cursor(6'd0, cur_row + 3'd1);
            if (w.char_code != lcdx_pkg::CHAR_NL) begin
               send_lcd_byte(1'b1, w.char_code);
               cur_col = cur_col + 6'd1;
            end else begin
               move_cursor(6'd0, cur_row + 3'd1);
            end
         end
         lcdx_pkg::CMD_GOTO: move_cursor(w.column, {1'b0, w.row});
         lcdx_pkg::CMD_CLEAR: begin
            send_lcd_byte(1'b0, lcdx_pkg::LCD_CLEAR);
            cur_col = 6'd0;
            cur_row = 3'd0;
         end
         lcdx_pkg::CMD_BACKLIGHT: begin
            // active low: clearing the bit turns the light on
            if (w.backlight_on)
               drive_port(shadow_byte & ~lcdx_pkg::BL_BIT, lcdx_pkg::WAIT_NONE);
            else
               drive_port(shadow_byte | lcdx_pkg::BL_BIT, lcdx_pkg::WAIT_NONE);
         end
         default: ;
      endcase
      // cursor fields carry the position after the whole command
      foreach (port_run[i]) begin
         port_run[i].cursor_column = cur_col;
         port_run[i].cursor_row = cur_row;
         port_run[i].last = (i == port_run.size() - 1);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Directed table. Rows with typed = 1 carry their expected word (or
   // none, want_n = 0); the rest go through the predictor.
   // ---------------------------------------------------------------------
   typedef struct packed {
      lcdx_pkg::req_type word;
      logic              typed;
      logic              want_n;
      lcdx_pkg::rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows [22] = '{
      // backlight off straight after reset: shadow 0 plus the light bit
      '{'{lcdx_pkg::CMD_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b0}, 1'b1, 1'b1,
        '{8'h40, lcdx_pkg::WAIT_NONE, 6'd0, 3'd0, 1'b1}},
      // and back on, other fields at their top
      '{'{lcdx_pkg::CMD_BACKLIGHT, 8'hFF, 6'd63, 2'd3, 1'b1}, 1'b1, 1'b1,
        '{8'h00, lcdx_pkg::WAIT_NONE, 6'd0, 3'd0, 1'b1}},
      // ignored codes, no port words at all
      '{'{CMD_RESERVED_LO, 8'h00, 6'd0, 2'd0, 1'b0}, 1'b1, 1'b0, '0},
      '{'{CMD_RESERVED_HI, 8'hFF, 6'd63, 2'd3, 1'b1}, 1'b1, 1'b0, '0},
      '{'{lcdx_pkg::CMD_INIT,  8'h0C, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'h41, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'hFF, 6'd63, 2'd3, 1'b1}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'h00, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   lcdx_pkg::CHAR_NL, 6'd0, 2'd0, 1'b0}, 1'b0, 1'b0, '0},
      // last column of row 1, then two chars: fill, then wrap past last row
      '{'{lcdx_pkg::CMD_GOTO,  8'h00, 6'd15, 2'd1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'h5A, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'h21, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      // column equal to line length folds to 0
      '{'{lcdx_pkg::CMD_GOTO,  8'h00, 6'd16, 2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_GOTO,  8'hFF, 6'd63, 2'd3, 1'b1}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_GOTO,  8'h00, 6'd0,  2'd2, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_CLEAR, 8'h00, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      // light off, then LCD traffic must keep the light bit in the shadow
      '{'{lcdx_pkg::CMD_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'h7E, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   lcdx_pkg::CHAR_NL, 6'd63, 2'd3, 1'b1}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_INIT,  8'hFF, 6'd63, 2'd3, 1'b1}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b1}, 1'b0, 1'b0, '0},
      '{'{lcdx_pkg::CMD_PUT,   8'h80, 6'd0,  2'd0, 1'b0}, 1'b0, 1'b0, '0}
   };

   // Line setups for the random phases; index 4 is rolled at run time
   lcdx_pkg::cfg_type line_settings [6] = '{
      '{3'd1, 6'd1,  7'd0,   7'd127, 7'd0,   7'd0},
      '{3'd4, 6'd63, 7'd127, 7'd0,   7'd64,  7'd100},
      '{3'd2, 6'd16, 7'd0,   7'd64,  7'd20,  7'd84},
      '{3'd4, 6'd5,  7'd0,   7'd64,  7'd20,  7'd84},
      '{3'd3, 6'd8,  7'd0,   7'd0,   7'd0,   7'd0},
      '{3'd2, 6'd3,  7'd127, 7'd127, 7'd127, 7'd127}
   };

   // ---------------------------------------------------------------------
   // Flow control and bookkeeping
   // ---------------------------------------------------------------------
   int send_idle_pct  = 10;
   int recv_stall_pct = 86;
   int cycle_count    = 0;
   int mismatches     = 0;
   int words_checked  = 0;
   int commands_sent  = 0;
   int ignored_sent   = 0;
   int settings_run   = 1;
   lcdx_pkg::rsp_type due_word;

   // receiver stall, redrawn every cycle
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: %0d port words still expected", port_words_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic flag_mismatch(string what, int got, int want);
      if (mismatches < MAX_PRINTED)
         $display("mismatch on port word %0d: %s got %0d want %0d",
                  words_checked, what, got, want);
      mismatches++;
   endtask

   // Result checker: compare each accepted port word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (port_words_due.size() == 0) begin
            flag_mismatch("word with none expected, port_byte",
                          int'(rsp_payload.port_byte), -1);
         end else begin
            due_word = port_words_due.pop_front();
            if (rsp_payload.port_byte !== due_word.port_byte)
               flag_mismatch("port_byte", int'(rsp_payload.port_byte),
                             int'(due_word.port_byte));
            if (rsp_payload.wait_us !== due_word.wait_us)
               flag_mismatch("wait_us", int'(rsp_payload.wait_us), int'(due_word.wait_us));
            if (rsp_payload.cursor_column !== due_word.cursor_column)
               flag_mismatch("cursor_column", int'(rsp_payload.cursor_column),
                             int'(due_word.cursor_column));
            if (rsp_payload.cursor_row !== due_word.cursor_row)
               flag_mismatch("cursor_row", int'(rsp_payload.cursor_row),
                             int'(due_word.cursor_row));
            if (rsp_payload.last !== due_word.last)
               flag_mismatch("last", int'(rsp_payload.last), int'(due_word.last));
         end
         words_checked++;
      end
   end

   // Holds off the sender until every expected word is back. Always waits on
   // the clock before it returns, so valid is never lowered and raised in one step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (port_words_due.size() != 0);
   endtask

   // Presents one command word and waits for the handshake. Called at a
   // falling edge; returns at the falling edge after acceptance with valid
   // still high, so back-to-back words need no dead cycle.
   task automatic issue_command(lcdx_pkg::req_type w, logic typed, logic want_n,
                                lcdx_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      expand_command(w);
      if (typed) begin
         if (want_n) port_words_due.push_back(want);
      end else begin
         foreach (port_run[i]) port_words_due.push_back(port_run[i]);
      end
      if (w.command > lcdx_pkg::CMD_BACKLIGHT) ignored_sent++;
      else commands_sent++;
      req_payload <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Setup then access phase; the write lands at the edge inside the access phase
   task automatic write_register(logic [2:0] index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         lcdx_pkg::REG_LINE_COUNT:  lines_cfg.line_count = value[2:0];
         lcdx_pkg::REG_LINE_LENGTH: lines_cfg.line_length = value[5:0];
         lcdx_pkg::REG_LINE1_START: lines_cfg.line1_start = value[6:0];
         lcdx_pkg::REG_LINE2_START: lines_cfg.line2_start = value[6:0];
         lcdx_pkg::REG_LINE3_START: lines_cfg.line3_start = value[6:0];
         lcdx_pkg::REG_LINE4_START: lines_cfg.line4_start = value[6:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Random command word: mostly characters, with line ends and newlines
   // pushed hard; every field carries noise whatever the command.
   function automatic lcdx_pkg::req_type random_command();
      lcdx_pkg::req_type w;
      int pick;
      w.command = lcdx_pkg::CMD_PUT;
      w.char_code = 8'($urandom_range(255));
      w.column = 6'($urandom_range(63));
      w.row = 2'($urandom_range(3));
      w.backlight_on = 1'($urandom_range(1));
      pick = int'($urandom_range(99));
      if (pick < 4) begin
         w.command = lcdx_pkg::CMD_INIT;
      end else if (pick < 58) begin
         w.command = lcdx_pkg::CMD_PUT;
         if ($urandom_range(7) == 0) w.char_code = lcdx_pkg::CHAR_NL;
      end else if (pick < 76) begin
         w.command = lcdx_pkg::CMD_GOTO;
         case ($urandom_range(3))
            0: w.column = lines_cfg.line_length;
            1: w.column = lines_cfg.line_length - 6'd1;
            default: ;
         endcase
      end else if (pick < 82) begin
         w.command = lcdx_pkg::CMD_CLEAR;
      end else if (pick < 92) begin
         w.command = lcdx_pkg::CMD_BACKLIGHT;
      end else begin
         w.command = 3'($urandom_range(CMD_RESERVED_HI, CMD_RESERVED_LO));
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      lcdx_pkg::cfg_type next_setting;
      lcdx_pkg::req_type word;
      int phase_items;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows under the reset line setup, sender lightly idle and
      // receiver mostly stalled
      foreach (directed_rows[i])
         issue_command(directed_rows[i].word, directed_rows[i].typed,
                       directed_rows[i].want_n, directed_rows[i].want);

      for (int phase = 0; phase < 6; phase++) begin
         // swap the idle pattern: sender mostly idle, then nobody idles
         if (phase == 2) begin
            send_idle_pct = 86;
            recv_stall_pct = 10;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end

         // registers only change with the block idle
         wait_drained();
         repeat (SETTLE_CYCLES) @(negedge clock);
         next_setting = line_settings[phase];
         if (phase == 4) begin
            next_setting.line_count = 3'($urandom_range(4, 1));
            next_setting.line_length = 6'($urandom_range(63, 1));
            next_setting.line1_start = 7'($urandom_range(127));
            next_setting.line2_start = 7'($urandom_range(127));
            next_setting.line3_start = 7'($urandom_range(127));
            next_setting.line4_start = 7'($urandom_range(127));
         end
         write_register(lcdx_pkg::REG_LINE_COUNT,  {29'd0, next_setting.line_count});
         write_register(lcdx_pkg::REG_LINE_LENGTH, {26'd0, next_setting.line_length});
         write_register(lcdx_pkg::REG_LINE1_START, {25'd0, next_setting.line1_start});
         write_register(lcdx_pkg::REG_LINE2_START, {25'd0, next_setting.line2_start});
         write_register(lcdx_pkg::REG_LINE3_START, {25'd0, next_setting.line3_start});
         write_register(lcdx_pkg::REG_LINE4_START, {25'd0, next_setting.line4_start});
         settings_run++;

         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            // now and then let the pipeline run dry before the next word
            if ($urandom_range(29) == 0) wait_drained();
            word = random_command();
            issue_command(word, 1'b0, 1'b0, '0);
            phase_items++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d commands and %0d ignored words over %0d line setups,",
               commands_sent, ignored_sent, settings_run);
      $display("checked %0d port words under three idle patterns, %0d mismatches",
               words_checked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
